FILE: hw/rtl/rbh_pkg.sv
package rbh_pkg;

    // Coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int EFF_W   = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 1) ? 1 : COORD_WIDTH);
    localparam int FRAC_SH = (FRAC_BITS > 31) ? 31 : ((FRAC_BITS < 0) ? 0 : FRAC_BITS);

    // Divider sizing: numerator is |face - origin| (33 bits) scaled by the fraction
    localparam int NUM_W   = 33 + FRAC_SH;
    localparam int CMP_W   = (NUM_W > 63) ? NUM_W : 63;
    localparam int T_W     = 31;
    localparam int QBITS   = T_W;
    localparam int DIV_LAT = QBITS + 1;
    // input reg + face setup + divider + three check stages
    localparam int PIPE_LAT = DIV_LAT + 5;

    localparam logic [T_W-1:0] T_MAX = '1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    typedef logic [2:0][31:0] t_vec3;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] heading_x;
        logic signed [31:0] heading_y;
        logic signed [31:0] heading_z;
    } t_ray_in;

    typedef struct packed {
        logic            hit;
        logic [T_W-1:0]  hit_distance;
    } t_result;

    // Ray and box as per-axis vectors
    typedef struct packed {
        t_vec3 o;
        t_vec3 d;
    } t_ray;

    typedef struct packed {
        t_vec3 lo;
        t_vec3 hi;
    } t_box;

    // One candidate face per axis
    typedef struct packed {
        logic        act;
        logic [32:0] num;
        logic [31:0] den;
    } t_face;

    // Sign-extend from the effective coordinate width
    function automatic logic signed [31:0] sext(input logic [31:0] v);
        logic signed [31:0] s;
        s = $signed(v << (32 - EFF_W)) >>> (32 - EFF_W);
        return s;
    endfunction

    function automatic t_ray to_ray(input t_ray_in r);
        t_ray x;
        x.o[0] = sext(r.origin_x);
        x.o[1] = sext(r.origin_y);
        x.o[2] = sext(r.origin_z);
        x.d[0] = sext(r.heading_x);
        x.d[1] = sext(r.heading_y);
        x.d[2] = sext(r.heading_z);
        return x;
    endfunction

endpackage

FILE: hw/rtl/ray_box_hit_distance_unit.sv
// Channel   | Direction | Transfer when                  | Payload
// ray       | in        | i_start && !o_busy             | i_ray (t_ray_in)
// result    | out       | o_done (one cycle, no stall)   | o_result (t_result)
// config    | in        | i_cfg_valid && o_cfg_ready     | i_cfg_index, i_cfg_data
//
// Fully pipelined: one ray per cycle whenever o_busy is low.
// Latency is set by the long divider, one quotient bit per stage (31 stages plus
// an entry stage), followed by multiply, range test and nearest-face stages.
// Synchronous active-low reset clears valid bits and the box registers.
// Nothing stalls: o_busy is high during reset and for the first cycle after it.
module ray_box_hit_distance_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  rbh_pkg::t_ray_in        i_ray,
    output logic                    o_done,
    output rbh_pkg::t_result        o_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    localparam int DL = rbh_pkg::DIV_LAT;

    logic                  r_run;
    rbh_pkg::t_box         r_box;
    logic                  r_v0;
    rbh_pkg::t_ray         r_ray0;

    logic                  w_accept;
    logic                  w_v1, w_inside1;
    rbh_pkg::t_ray         w_ray1;
    rbh_pkg::t_face [2:0]  w_face1;
    logic [2:0][rbh_pkg::T_W-1:0] w_t;
    logic [2:0]            w_act;

    // Sideband delay matching the divider
    logic [DL-1:0]         r_vdly;
    logic                  r_idly [0:DL-1];
    rbh_pkg::t_ray         r_rdly [0:DL-1];
    logic [2:0]            r_adly [0:DL-1];

    assign w_accept    = i_start && !o_busy;
    assign o_busy      = !r_run;
    assign o_cfg_ready = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    // Box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rbh_pkg::t_cfg_idx'(i_cfg_index))
                rbh_pkg::CFG_MIN_X: r_box.lo[0] <= i_cfg_data;
                rbh_pkg::CFG_MIN_Y: r_box.lo[1] <= i_cfg_data;
                rbh_pkg::CFG_MIN_Z: r_box.lo[2] <= i_cfg_data;
                rbh_pkg::CFG_MAX_X: r_box.hi[0] <= i_cfg_data;
                rbh_pkg::CFG_MAX_Y: r_box.hi[1] <= i_cfg_data;
                rbh_pkg::CFG_MAX_Z: r_box.hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ray0 <= rbh_pkg::to_ray(i_ray);
    end

    rbh_face_setup u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v0),
        .i_ray    (r_ray0),
        .i_box    (r_box),
        .o_valid  (w_v1),
        .o_ray    (w_ray1),
        .o_inside (w_inside1),
        .o_face   (w_face1)
    );

    for (genvar k = 0; k < 3; k++) begin : g_div
        rbh_divider u_div (
            .i_clk (i_clk),
            .i_num (w_face1[k].num),
            .i_den (w_face1[k].den),
            .o_t   (w_t[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdly <= '0;
        end else begin
            r_vdly <= {r_vdly[DL-2:0], w_v1};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idly[0] <= w_inside1;
        r_rdly[0] <= w_ray1;
        r_adly[0] <= {w_face1[2].act, w_face1[1].act, w_face1[0].act};
        for (int s = 1; s < DL; s++) begin
            r_idly[s] <= r_idly[s-1];
            r_rdly[s] <= r_rdly[s-1];
            r_adly[s] <= r_adly[s-1];
        end
    end

    assign w_act = r_adly[DL-1];

    rbh_hit_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vdly[DL-1]),
        .i_inside (r_idly[DL-1]),
        .i_ray    (r_rdly[DL-1]),
        .i_box    (r_box),
        .i_act    (w_act),
        .i_t      (w_t),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    // Every result follows a ray transfer by the fixed latency
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, rbh_pkg::PIPE_LAT))
        else $error("result without matching ray");

    // A miss reports zero distance
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.hit) |-> (o_result.hit_distance == '0))
        else $error("miss with non-zero distance");

    // No result while the block reports busy
    a_no_done_in_reset: assert property (@(posedge i_clk)
        o_busy |-> !o_done)
        else $error("result while busy");

endmodule

FILE: hw/rtl/rbh_face_setup.sv
module rbh_face_setup (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  rbh_pkg::t_ray            i_ray,
    input  rbh_pkg::t_box            i_box,
    output logic                     o_valid,
    output rbh_pkg::t_ray            o_ray,
    output logic                     o_inside,
    output rbh_pkg::t_face [2:0]     o_face
);

    logic                 r_valid;
    rbh_pkg::t_ray        r_ray;
    logic                 r_inside;
    rbh_pkg::t_face [2:0] r_face;

    logic                 n_inside;
    rbh_pkg::t_face [2:0] n_face;

    // Per axis: pick the face the ray approaches from outside; also flag an origin strictly inside the box
    always_comb begin
        logic signed [31:0] o, d, lo, hi, face;
        logic signed [32:0] diff;
        logic               act_lo, act_hi;
        n_inside = 1'b1;
        for (int k = 0; k < 3; k++) begin
            o  = $signed(i_ray.o[k]);
            d  = $signed(i_ray.d[k]);
            lo = $signed(i_box.lo[k]);
            hi = $signed(i_box.hi[k]);
            act_lo = (o < lo) && (d > 0);
            act_hi = (o > hi) && (d < 0);
            face   = act_lo ? lo : hi;
            diff   = 33'(face) - 33'(o);
            n_face[k].act = act_lo || act_hi;
            n_face[k].num = diff[32] ? 33'(-diff) : 33'(diff);
            n_face[k].den = d[31] ? 32'(-33'(d)) : 32'(d);
            if (!((o > lo) && (o < hi))) begin
                n_inside = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ray    <= i_ray;
        r_inside <= n_inside;
        r_face   <= n_face;
    end

    assign o_valid  = r_valid;
    assign o_ray    = r_ray;
    assign o_inside = r_inside;
    assign o_face   = r_face;

endmodule

FILE: hw/rtl/rbh_divider.sv
module rbh_divider (
    input  logic                          i_clk,
    input  logic [32:0]                   i_num,
    input  logic [31:0]                   i_den,
    output logic [rbh_pkg::T_W-1:0]       o_t
);

    localparam int W = rbh_pkg::CMP_W;
    localparam int Q = rbh_pkg::QBITS;

    logic [W-1:0]              r_rem [0:Q];
    logic [31:0]               r_den [0:Q];
    logic [rbh_pkg::T_W-1:0]   r_q   [0:Q];
    logic                      r_ovf [0:Q];

    logic [W-1:0] n_num;
    logic [W-1:0] n_lim;

    // Entry: scale numerator, flag quotients that saturate
    assign n_num = W'(i_num) << rbh_pkg::FRAC_SH;
    assign n_lim = W'(i_den) << Q;

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= (n_num >= n_lim);
    end

    // One quotient bit per stage, most significant first
    for (genvar s = 1; s <= Q; s++) begin : g_step
        localparam int B = Q - s;
        logic [W-1:0]            sub;
        logic                    ge;
        logic [rbh_pkg::T_W-1:0] n_q;

        assign sub = W'(r_den[s-1]) << B;
        assign ge  = (r_rem[s-1] >= sub);

        always_comb begin
            n_q    = r_q[s-1];
            n_q[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? (r_rem[s-1] - sub) : r_rem[s-1];
            r_den[s] <= r_den[s-1];
            r_q[s]   <= n_q;
            r_ovf[s] <= r_ovf[s-1];
        end
    end

    assign o_t = r_ovf[Q] ? rbh_pkg::T_MAX : r_q[Q];

endmodule

FILE: hw/rtl/rbh_hit_check.sv
module rbh_hit_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_inside,
    input  rbh_pkg::t_ray                     i_ray,
    input  rbh_pkg::t_box                     i_box,
    input  logic [2:0]                        i_act,
    input  logic [2:0][rbh_pkg::T_W-1:0]      i_t,
    output logic                              o_valid,
    output rbh_pkg::t_result                  o_result
);

    // Stage A: products of heading and t on the two other axes
    logic                              r_va, r_inside_a;
    rbh_pkg::t_ray                     r_ray_a;
    logic [2:0][rbh_pkg::T_W-1:0]      r_t_a;
    logic [2:0]                        r_keep_a;
    logic [2:0][1:0][63:0]             r_prod_a;

    // Stage B: hit point range test
    logic                              r_vb, r_inside_b;
    logic [2:0][rbh_pkg::T_W-1:0]      r_t_b;
    logic [2:0]                        r_keep_b;

    // Stage C: result
    logic                              r_vc;
    rbh_pkg::t_result                  r_res;

    logic [2:0][1:0][63:0]             n_prod;
    logic [2:0]                        n_ok;
    rbh_pkg::t_result                  n_res;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [1:0] in_rng;
        for (genvar j = 0; j < 2; j++) begin : g_other
            localparam int B = (a + 1 + j) % 3;
            logic signed [63:0] coord;
            assign n_prod[a][j] = $signed(i_ray.d[B]) * $signed({1'b0, i_t[a]});
            assign coord = 64'($signed(r_ray_a.o[B]))
                         + ($signed(r_prod_a[a][j]) >>> rbh_pkg::FRAC_SH);
            assign in_rng[j] = (coord >= 64'($signed(i_box.lo[B])))
                            && (coord <= 64'($signed(i_box.hi[B])));
        end
        assign n_ok[a] = r_keep_a[a] && (&in_rng);
    end

    // Nearest kept face; an origin inside the box hits at zero distance
    always_comb begin
        logic                   found;
        logic [rbh_pkg::T_W-1:0] best;
        found = 1'b0;
        best  = '0;
        for (int a = 0; a < 3; a++) begin
            if (r_keep_b[a] && (!found || (r_t_b[a] < best))) begin
                found = 1'b1;
                best  = r_t_b[a];
            end
        end
        if (r_inside_b) begin
            n_res.hit          = 1'b1;
            n_res.hit_distance = '0;
        end else begin
            n_res.hit          = found;
            n_res.hit_distance = best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside_a <= i_inside;
        r_ray_a    <= i_ray;
        r_t_a      <= i_t;
        for (int a = 0; a < 3; a++) begin
            r_keep_a[a] <= i_act[a] && (i_t[a] != '0);
        end
        r_prod_a   <= n_prod;
        r_inside_b <= r_inside_a;
        r_t_b      <= r_t_a;
        r_keep_b   <= n_ok;
        r_res      <= n_res;
    end

    assign o_valid  = r_vc;
    assign o_result = r_res;

endmodule
